/* src/mbc_pkg.sv */
// Package for the monotonic bin classifier: shared constants, types and codes.
// Used by every module of the block; depends on nothing else.
package mbc_pkg;

  localparam int unsigned MaxEdgesDefault  = 64;
  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned CountW           = 7;
  localparam int unsigned IndexW           = 6;

  // Operation codes of an input transaction.
  localparam logic OpLoad     = 1'b0;
  localparam logic OpClassify = 1'b1;

  // Status codes of a result.
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusNonMono = 1'b1;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

/* src/monotonic_bin_classifier.sv */
// Top level of the monotonic bin classifier.
// Depends on mbc_pkg, mbc_front, mbc_queue and mbc_back.
//
// Input channel (valid_i/stall_o): op_i selects a load of one edge at
// edge_index_i or the classification of value_i (signed fixed point).
// Output channel (valid_o/stall_i): one transaction of bin_number_o and
// status_o for each classify; loads give nothing.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes edge_count;
// zero acts as one and values above MAX_EDGES saturate.
// A two-entry queue parts the front end from the back end. The back end
// takes a load whenever it is idle, so loads flow at one per cycle between
// scans. A classify scans the edge table memory one edge per cycle through
// its single read port, then registers the result and raises valid_o. A
// new classify starts only once the previous result has left.
// Reset empties the queue and the output; the edge table keeps no reset
// value and must be loaded before use. When the receiver stalls, the
// result is held and loads are still taken, but the next classify waits
// at the queue head; once the queue fills, stall_o rises.
module monotonic_bin_classifier import mbc_pkg::*; #(
  parameter int unsigned MAX_EDGES  = MaxEdgesDefault,
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic                  op_i,
  input  logic [IndexW-1:0]     edge_index_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [CountW-1:0]     bin_number_o,
  output logic                  status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CountW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_EDGES);
  localparam int unsigned NW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned JobW  = AddrW + VALUE_BITS + 1;

  logic [NW-1:0]   count_q;
  logic            push, full, pop, empty;
  logic [JobW-1:0] push_job, pop_job;

  // Edge count register, clamped on write.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= NW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0) count_q <= NW'(1);
      else if (32'(cfg_data_i) > MAX_EDGES) count_q <= NW'(MAX_EDGES);
      else count_q <= NW'(cfg_data_i);
    end
  end

  mbc_front #(.MaxEdges(MAX_EDGES), .ValueBits(VALUE_BITS)) u_front (
    .valid_i, .stall_o, .op_i, .edge_index_i, .value_i,
    .full_i(full), .push_o(push), .job_o(push_job)
  );

  mbc_queue #(.Width(JobW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_job), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_job), .empty_o(empty)
  );

  mbc_back #(.MaxEdges(MAX_EDGES), .ValueBits(VALUE_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(!empty),
    .job_op_i(pop_job[JobW-1]),
    .job_index_i(pop_job[JobW-2 -: AddrW]),
    .job_key_i(pop_job[VALUE_BITS-1:0]),
    .count_i(count_q),
    .job_pop_o(pop),
    .valid_o, .stall_i, .bin_number_o, .status_o
  );

endmodule

/* src/mbc_queue.sv */
// Two-entry queue between the front end and the back end of the classifier.
// Depends on mbc_pkg for nothing but house style; width is a parameter.
module mbc_queue import mbc_pkg::*; #(
  parameter int unsigned Width = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* src/mbc_back.sv */
// Back end: edge table memory and the sequential scan that classifies a sample.
// Depends on mbc_pkg for codes, states and widths.
module mbc_back import mbc_pkg::*; #(
  parameter int unsigned MaxEdges  = MaxEdgesDefault,
  parameter int unsigned ValueBits = ValueBitsDefault,
  localparam int unsigned AddrW    = $clog2(MaxEdges),
  localparam int unsigned NW       = $clog2(MaxEdges + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  logic                 job_op_i,
  input  logic [AddrW-1:0]     job_index_i,
  input  logic [ValueBits-1:0] job_key_i,
  input  logic [NW-1:0]        count_i,
  output logic                 job_pop_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [CountW-1:0]    bin_number_o,
  output logic                 status_o
);

  logic [ValueBits-1:0] mem_q [MaxEdges];
  logic [ValueBits-1:0] rd_q, prev_q, e0_q;
  state_e               state_q, state_d;
  logic [NW-1:0]        rd_addr_q;   // next address read
  logic [NW-1:0]        pos_q;       // index of the edge in rd_q
  logic                 dec_q, bad_q, found_q;
  logic [NW-1:0]        bin_q;
  logic [ValueBits-1:0] x_q;
  logic                 out_v_q;
  logic [CountW-1:0]    out_bin_q;
  logic                 out_st_q;
  logic                 start, mem_re;

  // Load writes the table; a classify starts a scan when the output is free.
  assign start     = job_valid_i && (job_op_i == OpClassify) && (state_q == StIdle)
                     && !out_v_q;
  assign job_pop_o = job_valid_i && (state_q == StIdle)
                     && ((job_op_i == OpLoad) || !out_v_q);
  assign mem_re    = start || (state_q == StScan);

  always_ff @(posedge clk_i) begin
    if (job_valid_i && state_q == StIdle && job_op_i == OpLoad)
      mem_q[job_index_i] <= job_key_i;
    if (mem_re)
      rd_q <= mem_q[start ? '0 : rd_addr_q[AddrW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StScan;
      StScan:  if (pos_q == count_i - NW'(1)) state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Scan: one edge per cycle; direction from the first pair, checks on each pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_addr_q <= '0;
      pos_q     <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (valid_o && !stall_i) out_v_q <= 1'b0;
      if (start) begin
        rd_addr_q <= NW'(1);
        pos_q     <= '0;
      end else if (state_q == StScan) begin
        rd_addr_q <= rd_addr_q + NW'(1);
        pos_q     <= pos_q + NW'(1);
      end
      if (state_q == StDone) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q     <= job_key_i;
      bad_q   <= 1'b0;
      found_q <= 1'b0;
      bin_q   <= '0;
    end else if (state_q == StScan) begin
      prev_q <= rd_q;
      if (pos_q == '0) begin
        e0_q <= rd_q;
        if (x_q < rd_q) begin
          found_q <= 1'b1;
          bin_q   <= '0;
        end
      end else begin
        if (pos_q == NW'(1)) begin
          dec_q <= (e0_q > rd_q);
          if (e0_q > rd_q) begin
            // Decreasing: bin is one past the last edge above x.
            bin_q <= (x_q < e0_q) ? ((x_q < rd_q) ? NW'(2) : NW'(1)) : '0;
          end else if (!found_q && x_q < rd_q) begin
            found_q <= 1'b1;
            bin_q   <= NW'(1);
          end
        end else if (dec_q) begin
          if (prev_q < rd_q) bad_q <= 1'b1;
          if (x_q < rd_q) bin_q <= pos_q + NW'(1);
        end else begin
          if (prev_q > rd_q) bad_q <= 1'b1;
          if (!found_q && x_q < rd_q) begin
            found_q <= 1'b1;
            bin_q   <= pos_q;
          end
        end
      end
    end
    if (state_q == StDone) begin
      out_st_q <= bad_q ? StatusNonMono : StatusOk;
      if (count_i == NW'(1))
        out_bin_q <= found_q ? '0 : CountW'(1);
      else if (bad_q)
        out_bin_q <= '0;
      else if (!dec_q && !found_q)
        out_bin_q <= CountW'(count_i);
      else
        out_bin_q <= CountW'(bin_q);
    end
  end

  assign valid_o      = out_v_q;
  assign bin_number_o = out_bin_q;
  assign status_o     = out_st_q;

endmodule

/* src/mbc_front.sv */
// Front end: accepts transactions, turns values into order keys, fills the queue.
// Depends on mbc_pkg for codes and widths.
module mbc_front import mbc_pkg::*; #(
  parameter int unsigned MaxEdges  = MaxEdgesDefault,
  parameter int unsigned ValueBits = ValueBitsDefault,
  localparam int unsigned AddrW    = $clog2(MaxEdges)
) (
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic                 op_i,
  input  logic [IndexW-1:0]    edge_index_i,
  input  logic [ValueBits-1:0] value_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [AddrW+ValueBits:0] job_o
);

  logic [IndexW:0] idx_ext;
  logic            in_range;

  // A load beyond the table is dropped here and never queued.
  assign idx_ext  = {1'b0, edge_index_i};
  assign in_range = (32'(idx_ext) < MaxEdges);
  assign stall_o  = full_i;
  assign push_o   = valid_i && !full_i && ((op_i == OpClassify) || in_range);
  assign job_o    = {op_i, AddrW'(edge_index_i),
                     value_i ^ {1'b1, {(ValueBits-1){1'b0}}}};

endmodule

/* src/mbc_checker.sv */
// Port-level checker for the monotonic bin classifier, bound to the top level.
// Depends on mbc_pkg for widths and codes.
module mbc_port_checker import mbc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_o,
  input logic              stall_i,
  input logic [CountW-1:0] bin_number_o,
  input logic              status_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(bin_number_o) && $stable(status_o))
    else $error("stalled result changed");

  // A flagged result carries bin zero.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StatusNonMono |-> bin_number_o == '0)
    else $error("non-monotonic result with nonzero bin");

  // Bin never exceeds the table size.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> 32'(bin_number_o) <= MaxEdgesDefault)
    else $error("bin out of range");

endmodule

bind monotonic_bin_classifier mbc_port_checker u_mbc_port_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .bin_number_o, .status_o
);

/* sim/mbc_checker.sv */
`timescale 1ns / 1ps
// Checker for the monotonic bin classifier: watches the input, output and
// configuration channels, predicts each result and compares. Depends on mbc_pkg.
module mbc_checker import mbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              stall_o,
  input  logic              op_i,
  input  logic [IndexW-1:0] edge_index_i,
  input  logic [31:0]       value_i,
  input  logic              valid_o,
  input  logic              stall_i,
  input  logic [CountW-1:0] bin_number_o,
  input  logic              status_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CountW-1:0] bin_number;
    logic              status;
  } bin_result_t;

  logic signed [31:0] edge_table [MaxEdgesDefault];
  logic [CountW-1:0]  count_reg;
  bin_result_t        expected_bins [$];

  // Classify one sample against the current edge table.
  function automatic bin_result_t classify_sample(logic signed [31:0] sample);
    bin_result_t r;
    int n;
    bit rising;
    r.bin_number = '0;
    r.status = StatusOk;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > MaxEdgesDefault) n = MaxEdgesDefault;
    if (n == 1) begin
      r.bin_number = (sample >= edge_table[0]) ? CountW'(1) : CountW'(0);
      return r;
    end
    rising = edge_table[0] <= edge_table[1];
    for (int i = 1; i + 1 < n; i++) begin
      if (rising ? (edge_table[i] > edge_table[i+1]) : (edge_table[i] < edge_table[i+1])) begin
        r.status = StatusNonMono;
        return r;
      end
    end
    if (rising) begin
      r.bin_number = CountW'(n);
      for (int i = 0; i < n; i++) begin
        if (sample < edge_table[i]) begin
          r.bin_number = CountW'(i);
          break;
        end
      end
    end else begin
      for (int i = n; i > 0; i--) begin
        if (sample < edge_table[i-1]) begin
          r.bin_number = CountW'(i);
          break;
        end
      end
    end
    return r;
  endfunction

  assign pending_o = expected_bins.size();

  // Track accepted transactions on every channel.
  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t got, want;
    if (!rst_ni) begin
      count_reg <= 1;
      fail_count_o <= 0;
      expected_bins.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) count_reg <= cfg_data_i;
      if (valid_i && !stall_o) begin
        if (op_i == OpLoad) edge_table[edge_index_i] <= value_i;
        else expected_bins.push_back(classify_sample(value_i));
      end
      if (valid_o && !stall_i) begin
        got.bin_number = bin_number_o;
        got.status = status_o;
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result bin %0d status %0d", $time,
                   got.bin_number, got.status);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_bins.pop_front();
          if (got != want) begin
            $display("%0t: expected bin %0d status %0d, got bin %0d status %0d",
                     $time, want.bin_number, want.status, got.bin_number, got.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the bin classifier testbench: clock, reset, stimulus and verdict.
// Depends on mbc_pkg, monotonic_bin_classifier and mbc_checker.
module testbench;
  import mbc_pkg::*;

  logic clk, rst_n;
  logic valid_i, stall_o, op_i, valid_o, stall_i, status_o, cfg_valid_i, cfg_ready_o;
  logic [IndexW-1:0] edge_index_i;
  logic [31:0]       value_i;
  logic [CountW-1:0] bin_number_o, cfg_data_i;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct, hold_cycles;

  monotonic_bin_classifier dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o), .op_i(op_i),
    .edge_index_i(edge_index_i), .value_i(value_i), .valid_o(valid_o), .stall_i(stall_i),
    .bin_number_o(bin_number_o), .status_o(status_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  mbc_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o), .op_i(op_i),
    .edge_index_i(edge_index_i), .value_i(value_i), .valid_o(valid_o), .stall_i(stall_i),
    .bin_number_o(bin_number_o), .status_o(status_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random, or for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one transaction and wait until it is accepted. Valid stays high
  // after acceptance until an idle cycle or a pause of the sender drops it.
  task automatic send_item(logic op, logic [IndexW-1:0] idx, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk);
    end
    valid_i <= 1'b1;
    op_i <= op;
    edge_index_i <= idx;
    value_i <= val;
    do @(posedge clk); while (stall_o);
  endtask

  // Wait for all results, let the back end settle, then write edge_count.
  task automatic write_count(logic [CountW-1:0] n);
    valid_i <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Load a fresh table of at least n edges: increasing, decreasing or scrambled.
  task automatic load_table(int n);
    logic [31:0] v;
    int shape;
    shape = $urandom_range(9);
    v = (shape < 4) ? 32'h8000_0000 + $urandom_range(20) : 32'h7FFF_FFFF - $urandom_range(20);
    for (int i = 0; i < 64; i++) begin
      send_item(OpLoad, i, v);
      if (shape < 4) v = v + $urandom_range(3) * (32'h1 << $urandom_range(26));
      else if (shape < 8) v = v - $urandom_range(3) * (32'h1 << $urandom_range(26));
      else v = $urandom;
      if (i + 1 >= n && $urandom_range(1)) break;
    end
  endtask

  initial begin
    int counts [$];
    int n;
    valid_i = 0; op_i = 0; edge_index_i = 0; value_i = 0;
    stall_i = 0; cfg_valid_i = 0; cfg_data_i = 1;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: edge at zero, extreme samples, full ramp, counts, a bad table.
    send_item(OpLoad, 0, 32'h0);
    send_item(OpClassify, 0, 32'h0);
    send_item(OpClassify, 6'h3F, 32'hFFFF_FFFF);
    send_item(OpClassify, 0, 32'h8000_0000);
    send_item(OpClassify, 0, 32'h7FFF_FFFF);
    for (int i = 0; i < 64; i++) send_item(OpLoad, i, 32'h8000_0000 + i * 32'h0200_0000);
    write_count(0);
    send_item(OpClassify, 0, 32'h8000_0000);
    write_count(127);
    send_item(OpClassify, 0, 32'h7FFF_FFFF);
    send_item(OpClassify, 0, 32'h8000_0000);
    send_item(OpClassify, 0, 32'h8200_0000);
    write_count(2);
    send_item(OpLoad, 1, 32'h7FFF_0000);
    send_item(OpClassify, 0, 32'h0);
    send_item(OpClassify, 0, 32'h7FFF_0000);
    send_item(OpLoad, 1, 32'h8000_0000);
    send_item(OpLoad, 0, 32'h8000_0000);
    send_item(OpClassify, 0, 32'h8000_0000);
    write_count(3);
    send_item(OpLoad, 1, 32'h7FFF_FFFF);
    send_item(OpLoad, 2, 32'h0);
    send_item(OpClassify, 0, 32'h1);

    // Random phases with varied counts, sender idling and receiver stalls.
    counts = '{1, 64, 2, 64, 5, 1, 3, 16, 64, 4, 8, 2};
    for (int p = 0; p < counts.size(); p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      n = counts[p];
      write_count(n);
      load_table(n);
      if (p == 1) hold_cycles = 300;
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(19) == 0) send_item(OpLoad, $urandom_range(n - 1), rand_value());
        else send_item(OpClassify, $urandom, rand_value());
      end
    end

    valid_i <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("** monotonic_bin_classifier: PASSED **");
    else $display("** monotonic_bin_classifier: FAILED **");
    $finish;
  end

  initial begin
    #4ms;
    $display("** monotonic_bin_classifier: FAILED **");
    $finish;
  end

endmodule

/* files.f */
src/mbc_pkg.sv
src/mbc_queue.sv
src/mbc_back.sv
src/mbc_front.sv
src/monotonic_bin_classifier.sv
src/mbc_checker.sv
sim/mbc_checker.sv
sim/testbench.sv
